// File: rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared property shorthands for the checker module of the gray converter.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising edge, off while reset is low.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("same-cycle property failed");

// Next-cycle implication, sampled on the rising edge, off while reset is low.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("next-cycle property failed");

`endif

// File: rtl/core/pgc_pkg.sv
// ----------------------------------------------------------------------------
// pgc_pkg
// Widths, codes and constants shared by the gray converter and its checker.
// ----------------------------------------------------------------------------
`default_nettype none

package pgc_pkg;

    localparam int BYTE_W     = 8;
    localparam int ROW_W      = 13;
    localparam int S_TDATA_W  = 9 * BYTE_W;
    localparam int M_TDATA_W  = BYTE_W;
    localparam int M_TUSER_W  = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = ROW_W;

    localparam int MAX_ROW_PIXELS_DEF = 4096;
    localparam int PALETTE_DEPTH_DEF  = 256;

    // Result flag positions inside the master tuser.
    localparam int TUSER_EOR = 0;
    localparam int TUSER_BAD = 1;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_PIXEL_FORMAT  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_DEPTH  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PAL_PRESENT   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PAL_HAS_ALPHA = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ROW_WIDTH     = 3'd4;

    // Pixel formats; codes above FMT_TC_ALPHA are unsupported.
    localparam logic [2:0] FMT_GRAY       = 3'd0;
    localparam logic [2:0] FMT_TRUECOLOR  = 3'd1;
    localparam logic [2:0] FMT_INDEXED    = 3'd2;
    localparam logic [2:0] FMT_GRAY_ALPHA = 3'd3;
    localparam logic [2:0] FMT_TC_ALPHA   = 3'd4;

    // Sample depth codes.
    localparam logic [1:0] DEPTH_1 = 2'd0;
    localparam logic [1:0] DEPTH_2 = 2'd1;
    localparam logic [1:0] DEPTH_4 = 2'd2;
    localparam logic [1:0] DEPTH_8 = 2'd3;

    // Input word kinds carried on the slave tuser.
    localparam logic OP_PIXEL     = 1'b0;
    localparam logic OP_PAL_WRITE = 1'b1;

    localparam logic [ROW_W-1:0] ROW_WIDTH_RST = 13'd480;

    localparam logic [BYTE_W-1:0] GRAY_BAD = 8'd128;
    localparam logic [BYTE_W-1:0] OPAQUE   = 8'd255;
    localparam logic [BYTE_W-1:0] LUMA_R   = 8'd77;
    localparam logic [BYTE_W-1:0] LUMA_G   = 8'd150;
    localparam logic [BYTE_W-1:0] LUMA_B   = 8'd29;

endpackage

`default_nettype wire

// File: rtl/core/png_pixel_to_gray_converter.sv
// ----------------------------------------------------------------------------
// png_pixel_to_gray_converter
// Turns decoded PNG scanline pixels into 8-bit gray blended over white.
// ----------------------------------------------------------------------------
// Usage: each slave word is either one pixel (tuser low) or one palette entry
// write (tuser high). A pixel word carries one pixel of 8-bit samples or one
// packed byte of 1, 2 or 4 bit samples, which is unpacked MSB first into up to
// eight master words, one gray level each. tlast marks the last master word
// caused by a slave word; tuser flags the end of a scanline and bad modes.
// Order: a taken pixel word passes the issue stage, stages 1 to 3 and the
// output register; further master words of that word follow one per cycle
// while the master side takes them. The slave side is not ready again until
// every result of a pixel word has been issued; a palette write leaves it
// ready. The per-sample issue counter paces this: the palette memory has one
// read port, so one sample enters the pipeline per cycle unless it stalls.
// Reset: configuration returns to its defaults, the column counter clears and
// the pipeline empties; the palette keeps whatever it held and must be
// written before indexed pixels look it up.
// Stall: when the master side holds tready low while tvalid is high, the whole
// pipeline and the palette read register freeze; no word is dropped or repeated.
// ----------------------------------------------------------------------------
`default_nettype none

module png_pixel_to_gray_converter #(
    parameter int MAX_ROW_PIXELS = pgc_pkg::MAX_ROW_PIXELS_DEF,
    parameter int PALETTE_DEPTH  = pgc_pkg::PALETTE_DEPTH_DEF
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,

    // Configuration write port.
    input  wire logic                            cfg_we,
    input  wire logic [pgc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [pgc_pkg::CFG_DATA_W-1:0]  cfg_wdata,

    // Slave side.
    input  wire logic                            s_tvalid,
    output      logic                            s_tready,
    // tdata, lowest bit up: byte0, byte1, byte2, byte3, pal_index,
    // pal_red, pal_green, pal_blue, pal_alpha (8 bits each).
    input  wire logic [pgc_pkg::S_TDATA_W-1:0]   s_tdata,
    // tuser: opcode (0 pixel word, 1 palette write).
    input  wire logic                            s_tuser,

    // Master side.
    output      logic                            m_tvalid,
    input  wire logic                            m_tready,
    // tdata: gray (8 bits).
    output      logic [pgc_pkg::M_TDATA_W-1:0]   m_tdata,
    // tlast: last_of_run.
    output      logic                            m_tlast,
    // tuser, lowest bit up: end_of_row, bad_mode.
    output      logic [pgc_pkg::M_TUSER_W-1:0]   m_tuser
);

    import pgc_pkg::*;

    localparam int COL_W  = $clog2(MAX_ROW_PIXELS + 1);
    localparam int PAL_AW = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;
    localparam logic [ROW_W:0]  MAX_ROW  = (ROW_W + 1)'(MAX_ROW_PIXELS);
    localparam logic [BYTE_W:0] PAL_SIZE = (BYTE_W + 1)'(PALETTE_DEPTH);

    // ------------------------------------------------------------------
    // Slave word fields
    // ------------------------------------------------------------------
    logic [BYTE_W-1:0] in_byte0, in_byte1, in_byte2, in_byte3;
    logic [BYTE_W-1:0] in_pal_index, in_pal_red, in_pal_green, in_pal_blue;
    logic [BYTE_W-1:0] in_pal_alpha;

    assign in_byte0     = s_tdata[0*BYTE_W +: BYTE_W];
    assign in_byte1     = s_tdata[1*BYTE_W +: BYTE_W];
    assign in_byte2     = s_tdata[2*BYTE_W +: BYTE_W];
    assign in_byte3     = s_tdata[3*BYTE_W +: BYTE_W];
    assign in_pal_index = s_tdata[4*BYTE_W +: BYTE_W];
    assign in_pal_red   = s_tdata[5*BYTE_W +: BYTE_W];
    assign in_pal_green = s_tdata[6*BYTE_W +: BYTE_W];
    assign in_pal_blue  = s_tdata[7*BYTE_W +: BYTE_W];
    assign in_pal_alpha = s_tdata[8*BYTE_W +: BYTE_W];

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [2:0]       fmt_reg;
    logic [1:0]       depth_reg;
    logic             pal_present_reg;
    logic             pal_alpha_reg;
    logic [ROW_W-1:0] row_width_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fmt_reg         <= FMT_GRAY;
            depth_reg       <= DEPTH_8;
            pal_present_reg <= 1'b0;
            pal_alpha_reg   <= 1'b0;
            row_width_reg   <= ROW_WIDTH_RST;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_PIXEL_FORMAT:  fmt_reg         <= cfg_wdata[2:0];
                REG_SAMPLE_DEPTH:  depth_reg       <= cfg_wdata[1:0];
                REG_PAL_PRESENT:   pal_present_reg <= cfg_wdata[0];
                REG_PAL_HAS_ALPHA: pal_alpha_reg   <= cfg_wdata[0];
                REG_ROW_WIDTH:     row_width_reg   <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Mode decode. The user must change these only while the block is idle; the block does not enforce it.
    logic             cfg_bad;
    logic             pal_used;
    logic [3:0]       samples_per_word;
    logic [COL_W-1:0] width_eff;

    assign cfg_bad = (fmt_reg > FMT_TC_ALPHA) ||
                     ((depth_reg != DEPTH_8) && (fmt_reg != FMT_GRAY) &&
                      (fmt_reg != FMT_INDEXED));
    assign pal_used = (fmt_reg == FMT_INDEXED) && pal_present_reg;

    always_comb begin
        case (depth_reg)
            DEPTH_1: samples_per_word = 4'd8;
            DEPTH_2: samples_per_word = 4'd4;
            DEPTH_4: samples_per_word = 4'd2;
            default: samples_per_word = 4'd1;
        endcase
        if (cfg_bad) begin
            samples_per_word = 4'd1;
        end
    end

    // A zero width acts as one pixel, an oversized width as the maximum.
    always_comb begin
        if (row_width_reg == '0) begin
            width_eff = COL_W'(1);
        end else if ({1'b0, row_width_reg} > MAX_ROW) begin
            width_eff = COL_W'(MAX_ROW);
        end else begin
            width_eff = COL_W'({1'b0, row_width_reg});
        end
    end

    // ------------------------------------------------------------------
    // Handshake and pipeline advance
    // ------------------------------------------------------------------
    logic s_accept;
    logic adv;
    logic m_valid_reg;

    assign adv      = !m_valid_reg || m_tready;
    assign s_accept = s_tvalid && s_tready;

    // ------------------------------------------------------------------
    // Issue stage: holds one pixel word and hands out one sample a cycle while the pipeline advances.
    // ------------------------------------------------------------------
    logic              item_valid_reg;
    logic [3:0]        left_reg;
    logic [COL_W-1:0]  col_reg;
    logic [BYTE_W-1:0] sh_reg;
    logic [BYTE_W-1:0] b1_reg, b2_reg, b3_reg;
    logic              bad_reg;

    logic              issue;
    logic [BYTE_W-1:0] sample;
    logic [BYTE_W-1:0] sh_next;
    logic [COL_W:0]    col_inc;
    logic              eor;
    logic              last_issue;

    assign s_tready = !item_valid_reg;
    assign issue    = item_valid_reg && adv;

    // The next sample always sits in the top bits of the shift register.
    always_comb begin
        case (depth_reg)
            DEPTH_1: begin
                sample  = {7'd0, sh_reg[7]};
                sh_next = {sh_reg[6:0], 1'b0};
            end
            DEPTH_2: begin
                sample  = {6'd0, sh_reg[7:6]};
                sh_next = {sh_reg[5:0], 2'd0};
            end
            DEPTH_4: begin
                sample  = {4'd0, sh_reg[7:4]};
                sh_next = {sh_reg[3:0], 4'd0};
            end
            default: begin
                sample  = sh_reg;
                sh_next = sh_reg;
            end
        endcase
    end

    // A sample that ends the row also ends the word: padding is dropped.
    assign col_inc    = {1'b0, col_reg} + (COL_W + 1)'(1);
    assign eor        = col_inc >= {1'b0, width_eff};
    assign last_issue = (left_reg == 4'd1) || eor;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            item_valid_reg <= 1'b0;
            left_reg       <= '0;
            col_reg        <= '0;
        end else begin
            if (s_accept && (s_tuser == OP_PIXEL)) begin
                item_valid_reg <= 1'b1;
                left_reg       <= samples_per_word;
            end else if (issue) begin
                left_reg <= left_reg - 4'd1;
                if (last_issue) begin
                    item_valid_reg <= 1'b0;
                end
            end
            if (issue) begin
                col_reg <= eor ? '0 : col_inc[COL_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept && (s_tuser == OP_PIXEL)) begin
            sh_reg  <= in_byte0;
            b1_reg  <= in_byte1;
            b2_reg  <= in_byte2;
            b3_reg  <= in_byte3;
            bad_reg <= cfg_bad;
        end else if (issue) begin
            sh_reg <= sh_next;
        end
    end

    // ------------------------------------------------------------------
    // Palette memory: R, G, B, alpha in one word, one write and one read
    // port, read data registered together with the issued sample.
    // ------------------------------------------------------------------
    logic [4*BYTE_W-1:0] pal_mem [PALETTE_DEPTH];
    logic [4*BYTE_W-1:0] pal_rdata_reg;

    always_ff @(posedge aclk) begin
        if (s_accept && (s_tuser == OP_PAL_WRITE) &&
            ({1'b0, in_pal_index} < PAL_SIZE)) begin
            pal_mem[in_pal_index[PAL_AW-1:0]] <=
                {in_pal_red, in_pal_green, in_pal_blue, in_pal_alpha};
        end
        if (issue) begin
            pal_rdata_reg <= pal_mem[sample[PAL_AW-1:0]];
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: pick the gray source and the alpha for each sample.
    // ------------------------------------------------------------------
    logic              s1_valid_reg;
    logic [BYTE_W-1:0] s1_s_reg, s1_b1_reg, s1_b2_reg, s1_b3_reg;
    logic              s1_eor_reg, s1_last_reg, s1_bad_reg, s1_oor_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (adv) begin
            s1_valid_reg <= issue;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            s1_s_reg    <= sample;
            s1_b1_reg   <= b1_reg;
            s1_b2_reg   <= b2_reg;
            s1_b3_reg   <= b3_reg;
            s1_eor_reg  <= eor;
            s1_last_reg <= last_issue;
            s1_bad_reg  <= bad_reg;
            s1_oor_reg  <= {1'b0, sample} >= PAL_SIZE;
        end
    end

    logic [4*BYTE_W-1:0] pal_word;
    logic [BYTE_W-1:0]   lum_r, lum_g, lum_b;
    logic [15:0]         luma_sum;
    logic [BYTE_W-1:0]   luma;
    logic [BYTE_W-1:0]   expanded;
    logic [BYTE_W-1:0]   s1_gray, s1_alpha;

    // An index beyond the palette reads as black and fully transparent.
    assign pal_word = s1_oor_reg ? '0 : pal_rdata_reg;
    assign lum_r    = pal_used ? pal_word[31:24] : s1_s_reg;
    assign lum_g    = pal_used ? pal_word[23:16] : s1_b1_reg;
    assign lum_b    = pal_used ? pal_word[15:8]  : s1_b2_reg;
    assign luma_sum = 16'(lum_r) * 16'(LUMA_R) + 16'(lum_g) * 16'(LUMA_G) +
                      16'(lum_b) * 16'(LUMA_B);
    assign luma     = luma_sum[15:8];

    // Full-scale expansion of a low-depth sample is bit replication.
    always_comb begin
        case (depth_reg)
            DEPTH_1: expanded = {8{s1_s_reg[0]}};
            DEPTH_2: expanded = {4{s1_s_reg[1:0]}};
            DEPTH_4: expanded = {2{s1_s_reg[3:0]}};
            default: expanded = s1_s_reg;
        endcase
    end

    // Pixels without transparency blend with full alpha, which is exact.
    always_comb begin
        s1_alpha = OPAQUE;
        case (fmt_reg)
            FMT_GRAY:      s1_gray = expanded;
            FMT_TRUECOLOR: s1_gray = luma;
            FMT_INDEXED: begin
                s1_gray = pal_used ? luma : expanded;
                if (pal_used && pal_alpha_reg) begin
                    s1_alpha = pal_word[7:0];
                end
            end
            FMT_GRAY_ALPHA: begin
                s1_gray  = s1_s_reg;
                s1_alpha = s1_b1_reg;
            end
            FMT_TC_ALPHA: begin
                s1_gray  = luma;
                s1_alpha = s1_b3_reg;
            end
            default:       s1_gray = GRAY_BAD;
        endcase
        if (s1_bad_reg) begin
            s1_gray  = GRAY_BAD;
            s1_alpha = OPAQUE;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: blend numerator gray * a + 255 * (255 - a).
    // ------------------------------------------------------------------
    logic              s2_valid_reg;
    logic [BYTE_W-1:0] s2_gray_reg, s2_alpha_reg;
    logic              s2_eor_reg, s2_last_reg, s2_bad_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_valid_reg <= 1'b0;
        end else if (adv) begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            s2_gray_reg  <= s1_gray;
            s2_alpha_reg <= s1_alpha;
            s2_eor_reg   <= s1_eor_reg;
            s2_last_reg  <= s1_last_reg;
            s2_bad_reg   <= s1_bad_reg;
        end
    end

    logic [15:0] blend_num;

    assign blend_num = 16'(s2_gray_reg) * 16'(s2_alpha_reg) +
                       16'(OPAQUE) * 16'(OPAQUE - s2_alpha_reg);

    // ------------------------------------------------------------------
    // Stage 3: divide the numerator by 255.
    // ------------------------------------------------------------------
    logic              s3_valid_reg;
    logic [15:0]       s3_num_reg;
    logic              s3_eor_reg, s3_last_reg, s3_bad_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s3_valid_reg <= 1'b0;
        end else if (adv) begin
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            s3_num_reg  <= blend_num;
            s3_eor_reg  <= s2_eor_reg;
            s3_last_reg <= s2_last_reg;
            s3_bad_reg  <= s2_bad_reg;
        end
    end

    // (x + x/256) / 256 undershoots x / 255 by at most one; the remainder
    // check adds it back.
    logic [15:0]       div_sum;
    logic [BYTE_W-1:0] quot_est;
    logic [15:0]       rem_est;
    logic [BYTE_W-1:0] quot;

    assign div_sum  = s3_num_reg + {8'd0, s3_num_reg[15:8]};
    assign quot_est = div_sum[15:8];
    assign rem_est  = s3_num_reg - ({quot_est, 8'd0} - {8'd0, quot_est});
    assign quot     = (rem_est >= 16'(OPAQUE)) ? quot_est + 8'd1 : quot_est;

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    logic [BYTE_W-1:0] m_gray_reg;
    logic              m_last_reg, m_eor_reg, m_bad_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (adv) begin
            m_valid_reg <= s3_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            m_gray_reg <= quot;
            m_last_reg <= s3_last_reg;
            m_eor_reg  <= s3_eor_reg;
            m_bad_reg  <= s3_bad_reg;
        end
    end

    assign m_tvalid           = m_valid_reg;
    assign m_tdata            = m_gray_reg;
    assign m_tlast            = m_last_reg;
    assign m_tuser[TUSER_EOR] = m_eor_reg;
    assign m_tuser[TUSER_BAD] = m_bad_reg;

endmodule

`default_nettype wire

// File: rtl/core/pgc_checker.sv
// ----------------------------------------------------------------------------
// pgc_checker
// Port-level properties of the gray converter, bound to its top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module pgc_checker (
    input wire logic                          aclk,
    input wire logic                          aresetn,
    input wire logic                          m_tvalid,
    input wire logic                          m_tready,
    input wire logic [pgc_pkg::M_TDATA_W-1:0] m_tdata,
    input wire logic                          m_tlast,
    input wire logic [pgc_pkg::M_TUSER_W-1:0] m_tuser
);

    import pgc_pkg::*;

    // A stalled master word keeps its contents.
    `ASSERT_NEXT(a_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast) && $stable(m_tuser))

    // An unsupported mode gives exactly one mid-gray word per pixel word.
    `ASSERT_IMPLIES(a_bad_word, aclk, aresetn, m_tvalid && m_tuser[TUSER_BAD], (m_tdata == GRAY_BAD) && m_tlast)

    // The end of a scanline always closes the run of its pixel word.
    `ASSERT_IMPLIES(a_eor_last, aclk, aresetn, m_tvalid && m_tuser[TUSER_EOR], m_tlast)

    // Reset empties the output register.
    `ASSERT_NEXT(a_reset_empty, aclk, 1'b1, !aresetn, !m_tvalid)

endmodule

bind png_pixel_to_gray_converter pgc_checker u_pgc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
);

`default_nettype wire

// File: bench/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for png_pixel_to_gray_converter: a table of directed
// pixel and palette words followed by random settings and random words.
// Every gray word is checked against an in-bench model of the converter.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
    import pgc_pkg::*;

    localparam int CYCLE_LIMIT     = 200000;
    localparam int SETTLE_CYCLES   = 12;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int RAND_PHASES     = 9;
    localparam int WORDS_PER_PHASE = 10;
    localparam int PAL_SEED        = 16;
    localparam int DIR_ROWS        = 37;

    // A format code well past the supported ones.
    localparam logic [2:0] FMT_UNDEFINED = 3'd7;

    typedef struct packed {
        logic        op;
        logic [7:0]  pa;
        logic [7:0]  pb;
        logic [7:0]  pg;
        logic [7:0]  pr;
        logic [7:0]  pidx;
        logic [7:0]  b3;
        logic [7:0]  b2;
        logic [7:0]  b1;
        logic [7:0]  b0;
    } pixel_word_t;

    typedef struct packed {
        logic [7:0] gray;
        logic       eor;
        logic       last;
        logic       bad;
    } gray_word_t;

    typedef enum logic [1:0] {ROW_CFG, ROW_PIX, ROW_PAL} row_kind_e;

    // For a setting row v0..v4 are format, depth, palette on, palette alpha
    // and row width; for a pixel row v0..v3 are the four bytes; for a palette
    // row v0..v4 are index, red, green, blue and alpha.
    typedef struct {
        row_kind_e kind;
        int        v0, v1, v2, v3, v4;
        bit        typed;
        int        gray_typed;
        bit        bad_typed;
    } dir_row_t;

    logic aclk = 1'b0;
    logic aresetn;
    logic cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;
    logic s_tvalid;
    logic s_tready;
    logic [S_TDATA_W-1:0] s_tdata;
    logic s_tuser;
    logic m_tvalid;
    logic m_tready;
    logic [M_TDATA_W-1:0] m_tdata;
    logic m_tlast;
    logic [M_TUSER_W-1:0] m_tuser;

    // Model state: current settings, column counter and palette copy.
    logic [2:0]  cur_fmt;
    logic [1:0]  cur_depth;
    logic        cur_pal_on;
    logic        cur_alpha_on;
    logic [12:0] cur_width;
    logic [12:0] column;
    logic [23:0] pal_rgb [256];
    logic [7:0]  pal_alpha [256];
    bit          pal_written [256];
    logic [7:0]  pal_known [$];

    gray_word_t gray_expect_q [$];

    bit idle_on;
    bit hold_req;
    int mismatch_count;
    int words_sent;
    int pal_writes;
    int grays_checked;
    int settings_seen;
    int cycle_count;

    always #5 aclk = ~aclk;

    png_pixel_to_gray_converter DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

    function automatic int luma8(int r, int g, int b);
        return (r * int'(LUMA_R) + g * int'(LUMA_G) + b * int'(LUMA_B)) >> 8;
    endfunction

    function automatic int over_white(int g, int a);
        int full;
        full = int'(OPAQUE);
        return (g * a + full * (full - a)) / full;
    endfunction

    function automatic int palette_gray(int idx);
        int g;
        g = luma8(pal_rgb[idx][23:16], pal_rgb[idx][15:8], pal_rgb[idx][7:0]);
        if (cur_alpha_on)
            g = over_white(g, pal_alpha[idx]);
        return g;
    endfunction

    // Updates the model for one accepted word and queues the gray words it
    // should produce, oldest first.
    function automatic void predict_gray(pixel_word_t w);
        int bits, mask, n, lim, s, g, k;
        logic bad, eor;
        gray_word_t r;
        if (w.op == OP_PAL_WRITE) begin
            pal_rgb[w.pidx]   = {w.pr, w.pg, w.pb};
            pal_alpha[w.pidx] = w.pa;
            if (!pal_written[w.pidx]) begin
                pal_written[w.pidx] = 1'b1;
                pal_known.push_back(w.pidx);
            end
            return;
        end
        bits = 1 << cur_depth;
        mask = (1 << bits) - 1;
        bad  = (cur_fmt > FMT_TC_ALPHA) ||
               (bits < 8 && cur_fmt != FMT_GRAY && cur_fmt != FMT_INDEXED);
        n    = (bad || bits == 8) ? 1 : 8 / bits;
        lim  = cur_width;
        if (lim < 1) lim = 1;
        if (lim > MAX_ROW_PIXELS_DEF) lim = MAX_ROW_PIXELS_DEF;
        for (k = 0; k < n; k++) begin
            s = (int'(w.b0) >> (8 - bits * (k + 1))) & mask;
            if (bad) begin
                g = GRAY_BAD;
            end else begin
                case (cur_fmt)
                    FMT_GRAY:       g = (bits == 8) ? s : s * 255 / mask;
                    FMT_TRUECOLOR:  g = luma8(w.b0, w.b1, w.b2);
                    FMT_INDEXED: begin
                        if (cur_pal_on)
                            g = palette_gray(s);
                        else
                            g = (bits == 8) ? s : s * 255 / mask;
                    end
                    FMT_GRAY_ALPHA: g = over_white(w.b0, w.b1);
                    default:        g = over_white(luma8(w.b0, w.b1, w.b2), w.b3);
                endcase
            end
            // A column already at or past a lowered width still ends the row.
            eor    = (int'(column) + 1) >= lim;
            column = eor ? 13'd0 : column + 13'd1;
            r.gray = 8'(g);
            r.eor  = eor;
            r.last = 1'b0;
            r.bad  = bad;
            gray_expect_q.push_back(r);
            if (eor) break;
        end
        r = gray_expect_q.pop_back();
        r.last = 1'b1;
        gray_expect_q.push_back(r);
    endfunction

    task automatic flag_mismatch(string msg);
        $display("tb: mismatch at cycle %0d: %s", cycle_count, msg);
        mismatch_count++;
    endtask

    // Offers one word, with an optional idle burst first, and runs the model
    // once the handshake completes. The caller lowers tvalid when the stream
    // pauses.
    task automatic send_word(pixel_word_t w);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= w.op;
        s_tdata  <= {w.pa, w.pb, w.pg, w.pr, w.pidx, w.b3, w.b2, w.b1, w.b0};
        do @(posedge aclk); while (!s_tready);
        predict_gray(w);
        words_sent++;
        if (w.op == OP_PAL_WRITE)
            pal_writes++;
    endtask

    // Stops offering words, waits for every owed gray word, then lets a
    // trailing palette write settle inside the pipeline.
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (gray_expect_q.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic configure(logic [2:0] fmt, logic [1:0] depth, logic pal_on,
                             logic alpha_on, logic [12:0] width);
        logic [CFG_IDX_W-1:0]  idx [5];
        logic [CFG_DATA_W-1:0] val [5];
        idx = '{REG_PIXEL_FORMAT, REG_SAMPLE_DEPTH, REG_PAL_PRESENT,
                REG_PAL_HAS_ALPHA, REG_ROW_WIDTH};
        val = '{13'(fmt), 13'(depth), 13'(pal_on), 13'(alpha_on), width};
        for (int i = 0; i < 5; i++) begin
            cfg_we    <= 1'b1;
            cfg_index <= idx[i];
            cfg_wdata <= val[i];
            @(posedge aclk);
        end
        cfg_we       <= 1'b0;
        cur_fmt      = fmt;
        cur_depth    = depth;
        cur_pal_on   = pal_on;
        cur_alpha_on = alpha_on;
        cur_width    = width;
        settings_seen++;
    endtask

    // Receiver side: random stalls while idling is on, one long hold-off on
    // request so that the converter backs up into its input.
    initial begin : drive_ready
        m_tready <= 1'b0;
        @(posedge aclk);
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge aclk);
            end else if (idle_on && $urandom_range(0, 4) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 15)) @(posedge aclk);
            end else begin
                m_tready <= 1'b1;
                @(posedge aclk);
            end
        end
    end

    always @(posedge aclk) begin : check_gray
        gray_word_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (gray_expect_q.size() == 0) begin
                flag_mismatch($sformatf("gray word %0d with nothing owed", m_tdata));
            end else begin
                want = gray_expect_q.pop_front();
                grays_checked++;
                if (m_tdata !== want.gray)
                    flag_mismatch($sformatf("gray %0d, wanted %0d", m_tdata, want.gray));
                if (m_tuser[TUSER_EOR] !== want.eor)
                    flag_mismatch($sformatf("end of row %b, wanted %b",
                                            m_tuser[TUSER_EOR], want.eor));
                if (m_tlast !== want.last)
                    flag_mismatch($sformatf("tlast %b, wanted %b", m_tlast, want.last));
                if (m_tuser[TUSER_BAD] !== want.bad)
                    flag_mismatch($sformatf("bad mode %b, wanted %b",
                                            m_tuser[TUSER_BAD], want.bad));
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb: gave up after %0d cycles with %0d gray words owed",
                     cycle_count, gray_expect_q.size());
            $display("tb NOT OK");
            $finish;
        end
    end

    initial begin : stimulus
        dir_row_t    dir_table [DIR_ROWS];
        dir_row_t    row;
        pixel_word_t w;
        gray_word_t  r;
        logic [2:0]  fmt;
        logic [1:0]  depth;
        logic [12:0] width;

        aresetn   <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tuser   <= OP_PIXEL;
        s_tdata   <= '0;
        cfg_we    <= 1'b0;
        cfg_index <= REG_PIXEL_FORMAT;
        cfg_wdata <= '0;
        cur_fmt      = FMT_GRAY;
        cur_depth    = DEPTH_8;
        cur_pal_on   = 1'b0;
        cur_alpha_on = 1'b0;
        cur_width    = ROW_WIDTH_RST;
        column       = '0;
        idle_on      = 1'b1;
        hold_req     = 1'b0;

        // Typed expectations sit only on rows whose gray level is obvious.
        dir_table = '{
            // Reset settings: plain 8-bit gray, extremes pass straight through.
            '{ROW_PIX, 0, 0, 0, 0, 0, 1, 0, 0},
            '{ROW_PIX, 255, 0, 0, 0, 0, 1, 255, 0},
            // Truecolor, short row so that end of row shows up early.
            '{ROW_CFG, FMT_TRUECOLOR, DEPTH_8, 0, 0, 3, 0, 0, 0},
            '{ROW_PIX, 255, 255, 255, 0, 0, 1, 255, 0},
            '{ROW_PIX, 0, 0, 0, 255, 0, 1, 0, 0},
            '{ROW_PIX, 200, 100, 50, 0, 0, 0, 0, 0},
            // Gray with alpha: fully transparent is white, opaque black is 0.
            '{ROW_CFG, FMT_GRAY_ALPHA, DEPTH_8, 0, 0, 5, 0, 0, 0},
            '{ROW_PIX, 0, 0, 0, 0, 0, 1, 255, 0},
            '{ROW_PIX, 0, 255, 0, 0, 0, 1, 0, 0},
            '{ROW_CFG, FMT_TC_ALPHA, DEPTH_8, 0, 0, 5, 0, 0, 0},
            '{ROW_PIX, 0, 0, 0, 255, 0, 1, 0, 0},
            '{ROW_PIX, 255, 255, 255, 0, 0, 1, 255, 0},
            '{ROW_PIX, 10, 20, 30, 128, 0, 0, 0, 0},
            // Palette writes give no gray word; index 255 is the top entry.
            '{ROW_PAL, 0, 255, 255, 255, 0, 0, 0, 0},
            '{ROW_PAL, 1, 0, 0, 0, 255, 0, 0, 0},
            '{ROW_PAL, 2, 90, 180, 45, 128, 0, 0, 0},
            '{ROW_PAL, 3, 255, 0, 255, 255, 0, 0, 0},
            '{ROW_PAL, 255, 128, 64, 32, 77, 0, 0, 0},
            // Packed 2-bit indexes 0, 1, 2, 3 through the palette with alpha.
            '{ROW_CFG, FMT_INDEXED, DEPTH_2, 1, 1, 8, 0, 0, 0},
            '{ROW_PIX, 8'h1B, 0, 0, 0, 0, 0, 0, 0},
            '{ROW_CFG, FMT_INDEXED, DEPTH_8, 1, 0, 4096, 0, 0, 0},
            '{ROW_PIX, 255, 0, 0, 0, 0, 0, 0, 0},
            // 1-bit gray on a 5-pixel row: padding past the row is dropped.
            '{ROW_CFG, FMT_GRAY, DEPTH_1, 0, 0, 5, 0, 0, 0},
            '{ROW_PIX, 8'hA5, 0, 0, 0, 0, 0, 0, 0},
            // Indexed without palette scales up; the alpha flag has no effect.
            '{ROW_CFG, FMT_INDEXED, DEPTH_4, 0, 1, 16, 0, 0, 0},
            '{ROW_PIX, 8'h30, 0, 0, 0, 0, 0, 0, 0},
            // Unsupported modes give one mid-gray word with the flag set.
            '{ROW_CFG, FMT_UNDEFINED, DEPTH_8, 0, 0, 16, 0, 0, 0},
            '{ROW_PIX, 1, 2, 3, 4, 0, 1, 128, 1},
            '{ROW_CFG, FMT_TRUECOLOR, DEPTH_2, 0, 0, 16, 0, 0, 0},
            '{ROW_PIX, 8'h55, 8'hAA, 0, 0, 0, 1, 128, 1},
            // A zero width behaves as one pixel per row.
            '{ROW_CFG, FMT_GRAY, DEPTH_8, 0, 0, 0, 0, 0, 0},
            '{ROW_PIX, 77, 0, 0, 0, 0, 1, 77, 0},
            // A width above the maximum is clamped.
            '{ROW_CFG, FMT_GRAY, DEPTH_8, 0, 0, 8191, 0, 0, 0},
            '{ROW_PIX, 1, 0, 0, 0, 0, 1, 1, 0},
            '{ROW_PIX, 254, 0, 0, 0, 0, 1, 254, 0},
            // Width dropped below the column: the next pixel closes the row.
            '{ROW_CFG, FMT_GRAY, DEPTH_4, 0, 0, 1, 0, 0, 0},
            '{ROW_PIX, 8'h3C, 0, 0, 0, 0, 0, 0, 0}
        };

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int i = 0; i < DIR_ROWS; i++) begin
            row = dir_table[i];
            if (row.kind == ROW_CFG) begin
                wait_drained();
                configure(3'(row.v0), 2'(row.v1), 1'(row.v2), 1'(row.v3), 13'(row.v4));
            end else begin
                w = '0;
                if (row.kind == ROW_PAL) begin
                    w.op   = OP_PAL_WRITE;
                    w.pidx = 8'(row.v0);
                    w.pr   = 8'(row.v1);
                    w.pg   = 8'(row.v2);
                    w.pb   = 8'(row.v3);
                    w.pa   = 8'(row.v4);
                end else begin
                    w.op = OP_PIXEL;
                    w.b0 = 8'(row.v0);
                    w.b1 = 8'(row.v1);
                    w.b2 = 8'(row.v2);
                    w.b3 = 8'(row.v3);
                end
                send_word(w);
                if (row.typed) begin
                    r = gray_expect_q.pop_back();
                    r.gray = 8'(row.gray_typed);
                    r.bad  = row.bad_typed;
                    gray_expect_q.push_back(r);
                end
            end
        end

        // Fill the low palette entries so that every packed index is backed
        // by a written entry; deeper indexes come from the written list.
        for (int i = 0; i < PAL_SEED; i++) begin
            w = pixel_word_t'(73'({$urandom, $urandom, $urandom}));
            w.op   = OP_PAL_WRITE;
            w.pidx = 8'(i);
            send_word(w);
        end

        for (int phase = 0; phase < RAND_PHASES; phase++) begin
            // The last two phases run without any idling.
            idle_on = (phase < RAND_PHASES - 2) && ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 5) == 0)
                fmt = 3'($urandom_range(5, 7));
            else
                fmt = 3'($urandom_range(0, 4));
            depth = 2'($urandom_range(0, 3));
            case ($urandom_range(0, 5))
                0:       width = 13'd0;
                1:       width = 13'd1;
                2:       width = 13'd8191;
                3:       width = 13'd4096;
                default: width = 13'($urandom_range(2, 24));
            endcase
            wait_drained();
            configure(fmt, depth, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                      width);
            if (phase == 2)
                hold_req = 1'b1;
            for (int j = 0; j < WORDS_PER_PHASE; j++) begin
                w = pixel_word_t'(73'({$urandom, $urandom, $urandom}));
                w.op = ($urandom_range(0, 6) == 0) ? OP_PAL_WRITE : OP_PIXEL;
                if (w.op == OP_PIXEL && cur_fmt == FMT_INDEXED && cur_pal_on &&
                    cur_depth == DEPTH_8)
                    w.b0 = pal_known[$urandom_range(0, pal_known.size() - 1)];
                send_word(w);
            end
        end

        wait_drained();
        $display("tb: %0d words sent, %0d of them palette writes, over %0d settings",
                 words_sent, pal_writes, settings_seen);
        $display("tb: %0d gray words checked, %0d mismatches", grays_checked,
                 mismatch_count);
        if (mismatch_count == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

endmodule

`default_nettype wire
